// ----- rtl/core/esm_pkg.sv -----
// ----------------------------------------------------------------------------
// esm_pkg
// Shared constants for the encoder speed meter: speed scale factor,
// configuration register map and saturation limits.
// ----------------------------------------------------------------------------
package esm_pkg;

  // 6_000_000_000 = 5_859_375 * 2^10; multiply by the odd part, then shift
  localparam int unsigned SPEED_MULT_W = 23;
  localparam logic [SPEED_MULT_W-1:0] SPEED_MULT = 23'd5859375;
  localparam int unsigned SPEED_SHIFT = 10;

  // configuration port
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned TPR_W = 16;

  typedef enum logic {
    REG_TICKS_PER_REV  = 1'b0,
    REG_COUNT_INVERTED = 1'b1
  } cfg_reg_t;

  localparam logic [TPR_W-1:0] TPR_RESET = 16'd1;

  // result limits
  localparam logic [31:0] RPM_POS_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] RPM_NEG_MAX = 32'h8000_0000;

endpackage

// ----- rtl/core/esm_in_if.sv -----
// ----------------------------------------------------------------------------
// esm_in_if
// Input channel: one encoder read per transaction.
// ----------------------------------------------------------------------------
interface esm_in_if;
  logic               valid;
  logic               ready;
  logic               mode;
  logic signed [31:0] encoder_count;
  logic        [31:0] timestamp_us;

  modport source (output valid, output mode, output encoder_count, output timestamp_us,
                  input ready);
  modport sink   (input valid, input mode, input encoder_count, input timestamp_us,
                  output ready);
endinterface

// ----- rtl/core/esm_out_if.sv -----
// ----------------------------------------------------------------------------
// esm_out_if
// Result channel: count difference, speed and interval flag per transaction.
// ----------------------------------------------------------------------------
interface esm_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] tick_delta;
  logic signed [31:0] rpm_x100;
  logic               interval_invalid;

  modport source (output valid, output tick_delta, output rpm_x100,
                  output interval_invalid, input ready);
  modport sink   (input valid, input tick_delta, input rpm_x100,
                  input interval_invalid, output ready);
endinterface

// ----- rtl/core/encoder_speed_meter_unit.sv -----
// ----------------------------------------------------------------------------
// encoder_speed_meter_unit
// Turns encoder count reads into a tick difference and, for speed reads, a speed in 0.01 rpm.
// ----------------------------------------------------------------------------
// One read is handled at a time. A count read (mode 0) and a speed read with
// zero elapsed time go from the transaction straight to the output write. A
// speed read passes through these steps in order, where DIV_W is the larger
// of COUNT_WIDTH + 33 and TIME_WIDTH + 16: the two multiplies are registered,
// the divider is started, a restoring divider produces DIV_W + 1 quotient
// bits, one quotient bit per cycle, the last being the rounding bit, then
// the block sees it finish, then a saturation step and the output write.
// The result sits in an output register; the block is ready for the next
// read in the cycle the result is posted and takes it while the result
// waits. A finished result that finds the output register still full holds
// until the register is emptied.
module encoder_speed_meter_unit #(
  parameter int unsigned COUNT_WIDTH = 32,
  parameter int unsigned TIME_WIDTH  = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  esm_in_if.sink                             in_if,
  esm_out_if.source                          out_if,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [esm_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [esm_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [esm_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                               pready
);

  localparam int unsigned TPR_W  = esm_pkg::TPR_W;
  localparam int unsigned PROD_W = COUNT_WIDTH + esm_pkg::SPEED_MULT_W;
  localparam int unsigned NUM_W  = PROD_W + esm_pkg::SPEED_SHIFT;
  localparam int unsigned DEN_W  = TPR_W + TIME_WIDTH;
  localparam int unsigned DIV_W  = (NUM_W > DEN_W) ? NUM_W : DEN_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_KICK,
    ST_DIV,
    ST_ROUND,
    ST_PUBLISH
  } state_t;

  // ---------------------------------------------------------------- config
  logic [TPR_W-1:0] tpr_r;
  logic             inv_r;
  logic             cfg_wr;
  logic             cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tpr_r <= esm_pkg::TPR_RESET;
      inv_r <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        esm_pkg::REG_TICKS_PER_REV:  tpr_r <= pwdata[TPR_W-1:0];
        esm_pkg::REG_COUNT_INVERTED: inv_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      esm_pkg::REG_TICKS_PER_REV:  prdata = esm_pkg::CFG_DATA_W'(tpr_r);
      esm_pkg::REG_COUNT_INVERTED: prdata = esm_pkg::CFG_DATA_W'(inv_r);
      default:                     prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- datapath
  state_t                  state_r;
  logic [COUNT_WIDTH-1:0]  last_count_r;
  logic [TIME_WIDTH-1:0]   last_time_r;
  logic [COUNT_WIDTH-1:0]  mag_r;
  logic [TIME_WIDTH-1:0]   elapsed_r;
  logic                    rneg_r;
  logic [DIV_W-1:0]        num_r;
  logic [DIV_W-1:0]        den_r;
  logic [31:0]             res_diff_r;
  logic [31:0]             res_rpm_r;
  logic                    res_inv_r;
  logic                    out_valid_r;
  logic [31:0]             out_diff_r;
  logic [31:0]             out_rpm_r;
  logic                    out_inv_r;

  logic                          in_fire;
  logic                          out_fire;
  logic                          publish;
  logic [COUNT_WIDTH-1:0]        cnt;
  logic [TIME_WIDTH+31:0]        ts_ext;
  logic [TIME_WIDTH-1:0]         ts;
  logic [COUNT_WIDTH-1:0]        diff;
  logic [COUNT_WIDTH-1:0]        shown;
  logic signed [COUNT_WIDTH-1:0] shown_s;
  logic [TIME_WIDTH-1:0]         elapsed;
  logic                          negate;
  logic [TPR_W-1:0]              tpr_eff;
  logic [PROD_W-1:0]             prod;
  logic [DEN_W-1:0]              den;
  logic                          div_start;
  logic                          div_done;
  logic [DIV_W:0]                div_quo;
  logic [DIV_W-1:0]              q;
  logic                          q_hi;
  logic [32:0]                   q_rnd;
  logic [31:0]                   rpm_sat;

  assign in_fire = in_if.valid && in_if.ready;
  assign out_fire = out_if.valid && out_if.ready;
  // move the finished result out when the output register is free or being emptied
  assign publish = (state_r == ST_PUBLISH) && (!out_valid_r || out_if.ready);
  assign cnt     = in_if.encoder_count[COUNT_WIDTH-1:0];
  assign ts_ext  = {{TIME_WIDTH{1'b0}}, in_if.timestamp_us};
  assign ts      = ts_ext[TIME_WIDTH-1:0];
  assign diff    = cnt - last_count_r;
  assign negate  = ~inv_r;
  assign shown   = negate ? (COUNT_WIDTH'(0) - diff) : diff;
  assign shown_s = shown;
  assign elapsed = ts - last_time_r;

  assign tpr_eff = (tpr_r == '0) ? esm_pkg::TPR_RESET : tpr_r;
  assign prod    = PROD_W'(mag_r) * PROD_W'(esm_pkg::SPEED_MULT);
  assign den     = DEN_W'(tpr_eff) * DEN_W'(elapsed_r);

  assign div_start = (state_r == ST_KICK);

  esm_divider #(.W(DIV_W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (num_r),
    .divisor  (den_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  // low quotient bit is the half-way bit: add it to round away from zero
  assign q     = div_quo[DIV_W:1];
  assign q_hi  = |q[DIV_W-1:32];
  assign q_rnd = {1'b0, q[31:0]} + 33'(div_quo[0]);

  always_comb begin
    if (rneg_r) begin
      if (q_hi || (q_rnd > {1'b0, esm_pkg::RPM_NEG_MAX})) begin
        rpm_sat = esm_pkg::RPM_NEG_MAX;
      end else begin
        rpm_sat = 32'd0 - q_rnd[31:0];
      end
    end else begin
      if (q_hi || (q_rnd > {1'b0, esm_pkg::RPM_POS_MAX})) begin
        rpm_sat = esm_pkg::RPM_POS_MAX;
      end else begin
        rpm_sat = q_rnd[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      last_count_r <= '0;
      last_time_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (publish) begin
        out_valid_r <= 1'b1;
        out_diff_r  <= res_diff_r;
        out_rpm_r   <= res_rpm_r;
        out_inv_r   <= res_inv_r;
      end else if (out_fire) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            res_diff_r <= 32'(shown_s);
            res_rpm_r  <= '0;
            res_inv_r  <= 1'b0;
            if (!in_if.mode) begin
              last_count_r <= cnt;
              last_time_r  <= ts;
              state_r      <= ST_PUBLISH;
            end else if (elapsed == '0) begin
              // no time passed: flag it and leave the history alone
              res_diff_r <= '0;
              res_inv_r  <= 1'b1;
              state_r    <= ST_PUBLISH;
            end else begin
              last_count_r <= cnt;
              last_time_r  <= ts;
              mag_r        <= diff[COUNT_WIDTH-1] ? (COUNT_WIDTH'(0) - diff) : diff;
              elapsed_r    <= elapsed;
              rneg_r       <= diff[COUNT_WIDTH-1] ^ negate;
              state_r      <= ST_MUL;
            end
          end
        end
        ST_MUL: begin
          num_r   <= DIV_W'(prod) << esm_pkg::SPEED_SHIFT;
          den_r   <= DIV_W'(den);
          state_r <= ST_KICK;
        end
        ST_KICK: begin
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          if (div_done) begin
            state_r <= ST_ROUND;
          end
        end
        ST_ROUND: begin
          res_rpm_r <= rpm_sat;
          state_r   <= ST_PUBLISH;
        end
        ST_PUBLISH: begin
          // hold until the output register is free or being emptied
          if (publish) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_if.ready             = (state_r == ST_IDLE);
  assign out_if.valid            = out_valid_r;
  assign out_if.tick_delta       = out_diff_r;
  assign out_if.rpm_x100         = out_rpm_r;
  assign out_if.interval_invalid = out_inv_r;

endmodule

// ----- rtl/core/esm_divider.sv -----
// ----------------------------------------------------------------------------
// esm_divider
// Restoring divider, one quotient bit per cycle. The dividend is extended by
// one zero bit, so the last quotient bit is the half-way rounding bit.
// ----------------------------------------------------------------------------
module esm_divider #(
  parameter int unsigned W = 65
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W:0]   quotient
);

  localparam int unsigned CNT_W = $clog2(W + 1);

  logic [W:0]       dvd_r;
  logic [W-1:0]     rem_r;
  logic [W-1:0]     dsr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [W:0]   rem_sh;
  logic [W+1:0] trial;
  logic         qbit;

  assign rem_sh = {rem_r, dvd_r[W]};
  assign trial  = {1'b0, rem_sh} - {2'b00, dsr_r};
  assign qbit   = ~trial[W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(W);
        dvd_r  <= {dividend, 1'b0};
        rem_r  <= '0;
        dsr_r  <= divisor;
      end else if (busy_r) begin
        // keep the remainder below the divisor; shift the quotient bit in
        rem_r <= qbit ? trial[W-1:0] : rem_sh[W-1:0];
        dvd_r <= {dvd_r[W-1:0], qbit};
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = dvd_r;

endmodule

// ----- rtl/core/esm_checker.sv -----
// ----------------------------------------------------------------------------
// esm_checker
// Port-level checks for the encoder speed meter, bound to the top level.
// ----------------------------------------------------------------------------
module esm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_tick_delta,
  input logic [31:0] out_rpm_x100,
  input logic        out_interval_invalid
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_tick_delta)
      && $stable(out_rpm_x100) && $stable(out_interval_invalid))
    else $error("result changed while stalled");

  // one read at a time: busy right after a transaction
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a read is in progress");

  // a zero-interval result carries no count and no speed
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_interval_invalid |-> out_tick_delta == 32'd0 && out_rpm_x100 == 32'd0)
    else $error("invalid interval result has nonzero fields");

  // reset empties the output register
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind encoder_speed_meter_unit esm_checker u_esm_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_valid             (in_if.valid),
  .in_ready             (in_if.ready),
  .out_valid            (out_if.valid),
  .out_ready            (out_if.ready),
  .out_tick_delta       (out_if.tick_delta),
  .out_rpm_x100         (out_if.rpm_x100),
  .out_interval_invalid (out_if.interval_invalid)
);

// ----- test/esm_speed_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// esm_speed_checker
// Watches the read, result and register channels of the encoder speed meter,
// predicts every result from its own copy of the state and settings, and
// compares each result transaction field by field in arrival order.
// ----------------------------------------------------------------------------
module esm_speed_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  esm_in_if                              in_ch,
  esm_out_if                             out_ch,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [esm_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [esm_pkg::CFG_DATA_W-1:0] pwdata,
  input  logic                           pready,
  output int                             fail_count,
  output int                             pending,
  output int                             matched
);

  typedef struct packed {
    logic signed [31:0] tick_delta;
    logic signed [31:0] rpm_x100;
    logic               interval_invalid;
  } speed_result_t;

  localparam logic [63:0] RPM_SCALE = 64'd6_000_000_000;

  logic [31:0]               prev_count;
  logic [31:0]               prev_time;
  logic [esm_pkg::TPR_W-1:0] ticks_rev;
  logic                      keep_sign;
  speed_result_t             expected_results[$];

  // Work out the result of one read and advance the stored count and time.
  function automatic speed_result_t predict_read(input logic mode, input logic [31:0] count,
                                                 input logic [31:0] stamp);
    speed_result_t res;
    logic [31:0]   delta;
    logic [31:0]   elapsed;
    logic [31:0]   mag;
    logic [63:0]   num;
    logic [63:0]   den;
    logic [63:0]   quo;
    logic [63:0]   rem;
    logic          flip;
    logic          dneg;
    logic          rneg;
    res     = '0;
    delta   = count - prev_count;
    elapsed = stamp - prev_time;
    flip    = !keep_sign;
    if (mode == 1'b1 && elapsed == 32'd0) begin
      // zero interval: flag it and leave the state alone
      res.interval_invalid = 1'b1;
      return res;
    end
    prev_count     = count;
    prev_time      = stamp;
    res.tick_delta = flip ? 32'd0 - delta : delta;
    if (mode == 1'b0)
      return res;
    dneg = delta[31];
    mag  = dneg ? 32'd0 - delta : delta;
    num  = 64'(mag) * RPM_SCALE;
    den  = 64'((ticks_rev == '0) ? 1 : ticks_rev) * 64'(elapsed);
    quo  = num / den;
    rem  = num % den;
    // round half away from zero on the magnitude
    if (rem >= den - rem)
      quo = quo + 64'd1;
    rneg = (dneg != flip) && (quo != 64'd0);
    if (rneg) begin
      if (quo > 64'(esm_pkg::RPM_NEG_MAX))
        quo = 64'(esm_pkg::RPM_NEG_MAX);
      res.rpm_x100 = 32'd0 - quo[31:0];
    end else begin
      if (quo > 64'(esm_pkg::RPM_POS_MAX))
        quo = 64'(esm_pkg::RPM_POS_MAX);
      res.rpm_x100 = quo[31:0];
    end
    return res;
  endfunction

  always @(posedge clk) begin : watch
    speed_result_t want;
    logic          good;
    if (!rst_n) begin
      prev_count = '0;
      prev_time  = '0;
      ticks_rev  = esm_pkg::TPR_RESET;
      keep_sign  = 1'b0;
      expected_results.delete();
      fail_count = 0;
      matched    = 0;
      pending    = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00) begin
        case (esm_pkg::cfg_reg_t'(paddr[esm_pkg::CFG_ADDR_W-1:2]))
          esm_pkg::REG_TICKS_PER_REV: begin
            ticks_rev = pwdata[esm_pkg::TPR_W-1:0];
          end
          esm_pkg::REG_COUNT_INVERTED: begin
            keep_sign = pwdata[0];
          end
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready)
        expected_results.push_back(predict_read(in_ch.mode, in_ch.encoder_count,
                                                in_ch.timestamp_us));
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: tick_delta %0d rpm_x100 %0d interval_invalid %0b",
                 out_ch.tick_delta, out_ch.rpm_x100, out_ch.interval_invalid);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          good = 1'b1;
          if (out_ch.tick_delta !== want.tick_delta) begin
            $error("tick_delta mismatch: expected %0d, actual %0d",
                   want.tick_delta, out_ch.tick_delta);
            good = 1'b0;
          end
          if (out_ch.rpm_x100 !== want.rpm_x100) begin
            $error("rpm_x100 mismatch: expected %0d, actual %0d",
                   want.rpm_x100, out_ch.rpm_x100);
            good = 1'b0;
          end
          if (out_ch.interval_invalid !== want.interval_invalid) begin
            $error("interval_invalid mismatch: expected %0b, actual %0b",
                   want.interval_invalid, out_ch.interval_invalid);
            good = 1'b0;
          end
          if (good)
            matched++;
          else
            fail_count++;
        end
      end
      pending = expected_results.size();
    end
  end

endmodule

// ----- test/tb_encoder_speed_meter_unit.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_encoder_speed_meter_unit
// Drives encoder reads and register writes into the speed meter under
// varying back-pressure; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_encoder_speed_meter_unit;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int BLOCK_READS = 48;

  logic                           clk;
  logic                           rst_n;
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [esm_pkg::CFG_ADDR_W-1:0] paddr;
  logic [esm_pkg::CFG_DATA_W-1:0] pwdata;
  logic [esm_pkg::CFG_DATA_W-1:0] prdata;
  logic                           pready;

  int          fail_count;
  int          pending;
  int          matched;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          reads_sent;
  int          speed_reads;
  int          settings_used;
  int          quiet_cycles;
  bit          hold_off_req;
  logic [31:0] cnt_now;
  logic [31:0] ts_now;

  esm_in_if  in_ch();
  esm_out_if out_ch();

  encoder_speed_meter_unit uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_ch),
    .out_if  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  esm_speed_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pready     (pready),
    .fail_count (fail_count),
    .pending    (pending),
    .matched    (matched)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Result side: random stalls, plus one long hold-off on request.
  initial begin : receiver
    int stall;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        for (stall = 0; stall < HOLD_OFF_CYCLES; stall++) begin
          out_ch.ready <= 1'b0;
          @(negedge clk);
        end
      end
      out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no transaction for %0d cycles, %0d results outstanding",
               quiet_cycles, pending);
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one read and hold it until the block takes it.
  task automatic send_read(input logic mode, input logic [31:0] count, input logic [31:0] stamp);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.mode          <= mode;
    in_ch.encoder_count <= count;
    in_ch.timestamp_us  <= stamp;
    cnt_now = count;
    ts_now  = stamp;
    @(posedge clk);
    while (!in_ch.ready)
      @(posedge clk);
    reads_sent++;
    if (mode)
      speed_reads++;
    @(negedge clk);
  endtask

  task automatic send_random_read();
    int   pick;
    logic mode;
    pick = $urandom_range(0, 99);
    mode = 1'($urandom_range(0, 1));
    if (pick < 65) begin
      // typical motion: moderate count change over a plausible interval
      send_read(mode, cnt_now + 32'($urandom_range(0, 40000)) - 32'd20000,
                ts_now + 32'($urandom_range(1, 500000)));
    end else if (pick < 75) begin
      send_read(mode, cnt_now + 32'($urandom_range(0, 200)) - 32'd100, ts_now);
    end else if (pick < 87) begin
      send_read(mode, $urandom(), $urandom());
    end else begin
      // large jump over a tiny interval drives the speed into saturation
      send_read(mode, cnt_now + 32'($urandom_range(0, 2000000)) - 32'd1000000,
                ts_now + 32'($urandom_range(1, 4)));
    end
  endtask

  // Hold input, then wait for every outstanding result before touching registers.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input esm_pkg::cfg_reg_t idx,
                           input logic [esm_pkg::CFG_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= esm_pkg::CFG_ADDR_W'({idx, 2'b00});
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready)
      @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_speed_config(input logic [esm_pkg::CFG_DATA_W-1:0] tpr,
                                  input logic [esm_pkg::CFG_DATA_W-1:0] inv);
    drain();
    write_reg(esm_pkg::REG_TICKS_PER_REV, tpr);
    write_reg(esm_pkg::REG_COUNT_INVERTED, inv);
    settings_used++;
  endtask

  task automatic random_config();
    logic [esm_pkg::CFG_DATA_W-1:0] tpr;
    case ($urandom_range(0, 4))
      0: tpr = 32'd1;
      1: tpr = 32'h0000_FFFF;
      2: tpr = 32'($urandom_range(1, 64));
      3: tpr = $urandom();
      default: tpr = 32'($urandom_range(100, 4096));
    endcase
    set_speed_config(tpr, $urandom());
  endtask

  task automatic random_phase(input int sender_pct, input int receiver_pct,
                              input bit long_stall);
    int blk;
    int k;
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
    for (blk = 0; blk < 3; blk++) begin
      random_config();
      if (long_stall && blk == 0)
        hold_off_req = 1'b1;
      for (k = 0; k < BLOCK_READS; k++)
        send_random_read();
    end
  endtask

  initial begin : stimulus
    rst_n               = 1'b0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    in_ch.valid         = 1'b0;
    in_ch.mode          = 1'b0;
    in_ch.encoder_count = '0;
    in_ch.timestamp_us  = '0;
    hold_off_req        = 1'b0;
    send_idle_pct       = 17;
    recv_idle_pct       = 47;
    reads_sent          = 0;
    speed_reads         = 0;
    settings_used       = 1;
    cnt_now             = '0;
    ts_now              = '0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: one tick per revolution, results negated
    send_read(1'b0, 32'd0, 32'd0);
    send_read(1'b1, 32'd100, 32'd0);                   // zero interval
    send_read(1'b1, 32'd100, 32'd1000);
    send_read(1'b1, 32'd101, 32'd4000001000);          // exact half, rounds away from zero
    send_read(1'b1, 32'd100, 32'd3705033704);          // time wraps, negative half
    send_read(1'b1, 32'h7FFF_FFFF, 32'd3705034705);    // saturates
    send_read(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_read(1'b1, 32'h7FFF_FFFF, 32'h0000_0000);     // most negative difference
    send_read(1'b0, 32'h8000_0000, 32'd5);
    send_read(1'b1, 32'h8000_0000, 32'd5);             // zero interval again

    set_speed_config(32'h0000_FFFF, 32'd1);
    send_read(1'b1, 32'h8000_0001, 32'd4000000005);    // speed rounds to zero
    send_read(1'b1, 32'h8000_0000, 32'd4000000006);
    send_read(1'b1, 32'h0000_0000, 32'd4000000007);
    send_read(1'b1, 32'h7FFF_FFFF, 32'd4000000008);
    send_read(1'b0, 32'h0000_0000, 32'hFFFF_FFFF);

    // zero ticks per revolution falls back to one
    set_speed_config(32'hFFFF_0000, 32'hFFFF_FFFE);
    send_read(1'b1, 32'd3, 32'd1);
    send_read(1'b1, 32'd3, 32'd9);
    send_read(1'b0, 32'h5555_5555, 32'hAAAA_AAAA);
    send_read(1'b0, 32'hAAAA_AAAA, 32'h5555_5555);

    random_phase(17, 47, 1'b0);
    random_phase(47, 17, 1'b0);
    random_phase(0, 0, 1'b1);

    drain();
    repeat (80) @(negedge clk);

    $display("Covered %0d encoder reads (%0d speed reads) over %0d register settings,",
             reads_sent, speed_reads, settings_used);
    $display("including zero intervals, time wrap, exact halves and saturation; %0d matched.",
             matched);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
